// ===== hdl/mchp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mchp_pkg
// Shared types and constants for the CONNECT header parser: item layouts,
// result status codes and protocol constants.
// ----------------------------------------------------------------------------
package mchp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  msg_code;
      logic [3:0]  fixed_flags;
      logic [27:0] body_len;
      logic [7:0]  proto_rev;
      logic        has_user;
      logic        has_pass;
      logic        lw_retain;
      logic [1:0]  lw_qos;
      logic        has_lw;
      logic        fresh_start;
      logic [15:0] idle_secs;
   } rsp_type;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_TOO_SMALL  = 3'd1;
   localparam logic [2:0] ST_LEN_TRUNC  = 3'd2;
   localparam logic [2:0] ST_LEN_LONG   = 3'd3;
   localparam logic [2:0] ST_BAD_TYPE   = 3'd4;
   localparam logic [2:0] ST_VHDR_SHORT = 3'd5;

   localparam logic [3:0]  PKT_CONNECT     = 4'd1;
   localparam logic [2:0]  LEN_BYTES_MAX   = 3'd5;
   localparam logic [27:0] NAME_LEN_BYTES  = 28'd2;
   localparam logic [27:0] KEEP_ALIVE_BYTES = 28'd2;

endpackage
`default_nettype wire

// ===== hdl/mchp_in_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mchp_in_reg
// Input register: holds one accepted byte item until the parser takes it.
// ----------------------------------------------------------------------------
module mchp_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mchp_pkg::req_type req_data,
   output logic                   item_valid,
   output mchp_pkg::req_type      item_data,
   input  wire logic              item_take
);
   import mchp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign req_ready  = !valid_ff || item_take;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !item_take);
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mchp_parse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mchp_parse
// Byte-wise parse state machine for the fixed header and CONNECT variable
// header, with the result register on its output.
// ----------------------------------------------------------------------------
module mchp_parse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire mchp_pkg::req_type item_data,
   output logic                   item_take,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mchp_pkg::rsp_type      rsp_data
);
   import mchp_pkg::*;

   typedef enum logic [3:0] {
      PH_FIRST, PH_LEN, PH_NLEN_H, PH_NLEN_L, PH_NAME,
      PH_LEVEL, PH_FLAGS, PH_KA_H, PH_KA_L, PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [27:0] accum_ff, accum_in;
   logic [2:0]  count_ff, count_in;
   logic [16:0] hbu_ff, hbu_in;
   logic [15:0] nlen_ff, nlen_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  level_ff, level_in;
   logic [7:0]  cflags_ff, cflags_in;
   logic [7:0]  kah_ff, kah_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   logic        res_valid;
   logic [2:0]  res_status;
   rsp_type     res_data;
   logic        check_end;
   logic [27:0] group;
   logic [7:0]  b;
   logic        last_b;
   logic        ok;

   assign b         = item_data.data_byte;
   assign last_b    = item_data.last_byte;
   assign item_take = item_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      phase_in   = phase_ff;
      type_in    = type_ff;
      accum_in   = accum_ff;
      count_in   = count_ff;
      hbu_in     = hbu_ff;
      nlen_in    = nlen_ff;
      left_in    = left_ff;
      level_in   = level_ff;
      cflags_in  = cflags_ff;
      kah_in     = kah_ff;
      res_valid  = 1'b0;
      res_status = ST_OK;
      check_end  = 1'b1;
      group      = 28'd0;
      unique case (phase_ff)
         PH_FIRST: begin
            type_in   = b;
            accum_in  = 28'd0;
            count_in  = 3'd0;
            hbu_in    = 17'd0;
            nlen_in   = 16'd0;
            left_in   = 16'd0;
            level_in  = 8'd0;
            cflags_in = 8'd0;
            kah_in    = 8'd0;
            if (last_b) begin
               res_valid  = 1'b1;
               res_status = ST_TOO_SMALL;
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            count_in = count_ff + 3'd1;
            if (count_in >= LEN_BYTES_MAX) begin
               res_valid  = 1'b1;
               res_status = ST_LEN_LONG;
            end else begin
               case (count_ff[1:0])
                  2'd0:    group = {21'd0, b[6:0]};
                  2'd1:    group = {14'd0, b[6:0], 7'd0};
                  2'd2:    group = {7'd0, b[6:0], 14'd0};
                  default: group = {b[6:0], 21'd0};
               endcase
               accum_in = accum_ff + group;
               if (!b[7]) begin
                  if (type_ff[7:4] != PKT_CONNECT) begin
                     res_valid  = 1'b1;
                     res_status = ST_BAD_TYPE;
                  end else if (accum_in < NAME_LEN_BYTES) begin
                     res_valid  = 1'b1;
                     res_status = ST_VHDR_SHORT;
                  end else begin
                     phase_in = PH_NLEN_H;
                  end
               end
            end
         end
         PH_NLEN_H: begin
            nlen_in  = {b, 8'd0};
            hbu_in   = 17'd1;
            phase_in = PH_NLEN_L;
         end
         PH_NLEN_L: begin
            nlen_in = {nlen_ff[15:8], b};
            hbu_in  = 17'd2;
            if (accum_in < (NAME_LEN_BYTES + {12'd0, nlen_in})) begin
               res_valid  = 1'b1;
               res_status = ST_VHDR_SHORT;
            end else if (nlen_in == 16'd0) begin
               if (accum_in < ({11'd0, hbu_in} + 28'd1)) begin
                  res_valid  = 1'b1;
                  res_status = ST_VHDR_SHORT;
               end else begin
                  phase_in = PH_LEVEL;
               end
            end else begin
               left_in  = nlen_in;
               phase_in = PH_NAME;
            end
         end
         PH_NAME: begin
            left_in = left_ff - 16'd1;
            hbu_in  = hbu_ff + 17'd1;
            if (left_in == 16'd0) begin
               if (accum_in < ({11'd0, hbu_in} + 28'd1)) begin
                  res_valid  = 1'b1;
                  res_status = ST_VHDR_SHORT;
               end else begin
                  phase_in = PH_LEVEL;
               end
            end
         end
         PH_LEVEL: begin
            level_in = b;
            hbu_in   = hbu_ff + 17'd1;
            if (accum_in < ({11'd0, hbu_in} + 28'd1)) begin
               res_valid  = 1'b1;
               res_status = ST_VHDR_SHORT;
            end else begin
               phase_in = PH_FLAGS;
            end
         end
         PH_FLAGS: begin
            cflags_in = b;
            hbu_in    = hbu_ff + 17'd1;
            if (accum_in < ({11'd0, hbu_in} + KEEP_ALIVE_BYTES)) begin
               res_valid  = 1'b1;
               res_status = ST_VHDR_SHORT;
            end else begin
               phase_in = PH_KA_H;
            end
         end
         PH_KA_H: begin
            kah_in   = b;
            hbu_in   = hbu_ff + 17'd1;
            phase_in = PH_KA_L;
         end
         PH_KA_L: begin
            hbu_in     = hbu_ff + 17'd1;
            res_valid  = 1'b1;
            res_status = ST_OK;
         end
         PH_SKIP: begin
            check_end = 1'b0;
            if (last_b) begin
               phase_in = PH_FIRST;
            end
         end
         default: begin
            check_end = 1'b0;
            phase_in  = PH_FIRST;
         end
      endcase

      if (check_end && !res_valid && last_b && (phase_in != PH_FIRST)) begin
         res_valid  = 1'b1;
         res_status = (phase_in == PH_LEN) ? ST_LEN_TRUNC : ST_VHDR_SHORT;
      end
      if (res_valid) begin
         phase_in = last_b ? PH_FIRST : PH_SKIP;
      end
   end

   always_comb begin
      ok                   = (res_status == ST_OK);
      res_data.status      = res_status;
      res_data.msg_code    = type_in[7:4];
      res_data.fixed_flags = type_in[3:0];
      res_data.body_len    = accum_in;
      res_data.proto_rev   = ok ? level_in : 8'd0;
      res_data.has_user    = ok & cflags_in[7];
      res_data.has_pass    = ok & cflags_in[6];
      res_data.lw_retain   = ok & cflags_in[5];
      res_data.lw_qos      = ok ? cflags_in[4:3] : 2'd0;
      res_data.has_lw      = ok & cflags_in[2];
      res_data.fresh_start = ok & cflags_in[1];
      res_data.idle_secs   = ok ? {kah_in, b} : 16'd0;
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (item_take && res_valid);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            phase_ff <= phase_in;
         end
      end
      if (item_take) begin
         type_ff   <= type_in;
         accum_ff  <= accum_in;
         count_ff  <= count_in;
         hbu_ff    <= hbu_in;
         nlen_ff   <= nlen_in;
         left_ff   <= left_in;
         level_ff  <= level_in;
         cflags_ff <= cflags_in;
         kah_ff    <= kah_in;
         if (res_valid) begin
            rsp_data_ff <= res_data;
         end
      end
   end

   a_ok_is_connect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == ST_OK) |->
         (rsp_data_ff.msg_code == PKT_CONNECT))
      else $error("ok result for a packet that is not CONNECT");

   a_err_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != ST_OK) |->
         (rsp_data_ff.proto_rev == 8'd0) && (rsp_data_ff.idle_secs == 16'd0))
      else $error("error result carries CONNECT fields");

   a_too_small_no_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == ST_TOO_SMALL) |->
         (rsp_data_ff.body_len == 28'd0))
      else $error("one-byte buffer reports a length");

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      item_take && item_data.last_byte |=> (phase_ff == PH_FIRST))
      else $error("final byte did not rearm the parser");

endmodule
`default_nettype wire

// ===== hdl/mqtt_connect_header_parser_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqtt_connect_header_parser_core
// Parses the fixed header and CONNECT variable header of a packet stream
// supplied one byte per item, giving one result item per packet.
// ----------------------------------------------------------------------------
// Takes one byte item every clock cycle when the result side keeps up. Each
// byte is held in an input register until the parse state machine takes it,
// and the result register captures the result when it takes the byte that
// completes it. One result item is produced per packet: the decoded
// header fields, or an error status; bytes after that are dropped until the
// byte marked last_byte, after which the next byte starts a new packet.
// ----------------------------------------------------------------------------
module mqtt_connect_header_parser_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mchp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mchp_pkg::rsp_type      rsp_data
);
   import mchp_pkg::*;

   logic    item_valid;
   logic    item_take;
   req_type item_data;

   mchp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take)
   );

   mchp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
